FILE: hdl/kthsel_pkg.sv
// kthsel_pkg: shared constants and types of the k-th largest selector
// used by the channel interfaces and the top level; depends on nothing
`default_nettype none

package kthsel_pkg;

  localparam int MAX_RANK = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(MAX_RANK);
  localparam int CNT_W    = $clog2(MAX_RANK + 1);
  localparam int RANK_W   = 7;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [RANK_W-1:0]        rank_t;

  // what to do once a minimum scan has finished
  typedef enum logic [1:0] {
    OP_REPLACE = 2'd0,
    OP_DROP    = 2'd1,
    OP_RESULT  = 2'd2
  } op_t;

  // rank of zero acts as one, rank above the store size acts as the store size
  function automatic cnt_t eff_rank(input rank_t k);
    cnt_t r;
    if (k == '0) begin
      r = cnt_t'(1);
    end else if (CNT_W'(k) > cnt_t'(MAX_RANK)) begin
      r = cnt_t'(MAX_RANK);
    end else begin
      r = CNT_W'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/kthsel_if.sv
// kthsel_in_if / kthsel_out_if: valid/ready channels of the k-th largest selector
// depends on kthsel_pkg for the payload types
`default_nettype none

interface kthsel_in_if;
  logic                valid;
  logic                ready;
  kthsel_pkg::data_t   value;
  logic                last_of_set;

  modport source(output valid, output value, output last_of_set, input ready);
  modport sink(input valid, input value, input last_of_set, output ready);
endinterface

interface kthsel_out_if;
  logic                valid;
  logic                ready;
  kthsel_pkg::data_t   kth_value;
  logic                fewer_than_k;

  modport source(output valid, output kth_value, output fewer_than_k, input ready);
  modport sink(input valid, input kth_value, input fewer_than_k, output ready);
endinterface

`default_nettype wire

FILE: hdl/kth_largest_topk_select_top.sv
// kth_largest_topk_select_top: keeps the k largest values of a streamed set and reports
// the k-th largest on the last value; depends on kthsel_pkg, kthsel_if
// one value at a time: each is transferred in S_IDLE, then checked in S_CHECK; with n kept
//   values a drop scan, or a replace scan into a full store, reads all n (one read port, one compare)
// result: after the last transfer and its drop or replace scan, a result scan finds the minimum
// reset: rst (synchronous) empties the store, sets rank_k to 1, clears the output
`default_nettype none

module kth_largest_topk_select_top (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire kthsel_pkg::rank_t     cfg_wdata,
  kthsel_in_if.sink                  in_ch,
  kthsel_out_if.source               out_ch
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_ACT   = 4'b1000
  } state_t;

  state_t              state;
  kthsel_pkg::op_t     op;
  kthsel_pkg::rank_t   rank_k;
  kthsel_pkg::cnt_t    count;
  kthsel_pkg::cnt_t    k_eff;
  kthsel_pkg::cnt_t    rd_idx;
  logic                rd_valid;
  kthsel_pkg::idx_t    rd_tag;
  kthsel_pkg::data_t   rdata;
  kthsel_pkg::data_t   min_val;
  kthsel_pkg::idx_t    min_idx;
  kthsel_pkg::data_t   last_val;
  kthsel_pkg::data_t   in_val;
  logic                in_last;
  logic                out_valid;
  kthsel_pkg::data_t   kth_value;
  logic                fewer_than_k;

  kthsel_pkg::data_t   mem [kthsel_pkg::MAX_RANK];

  logic                accept;
  logic                issue;
  logic                tag_is_last;
  logic                scan_done;
  logic                emit;
  logic                mem_we;
  kthsel_pkg::idx_t    mem_waddr;
  kthsel_pkg::data_t   mem_wdata;

  assign k_eff       = kthsel_pkg::eff_rank(rank_k);
  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign issue       = (state == S_SCAN) && (rd_idx < count);
  assign tag_is_last = ({1'b0, rd_tag} == (count - kthsel_pkg::cnt_t'(1)));
  assign scan_done   = (state == S_SCAN) && rd_valid && tag_is_last;
  assign emit        = (state == S_ACT) && (op == kthsel_pkg::OP_RESULT) &&
                       (!out_valid || out_ch.ready);

  assign out_ch.valid        = out_valid;
  assign out_ch.kth_value    = kth_value;
  assign out_ch.fewer_than_k = fewer_than_k;

  // single write port of the value store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = min_idx;
    mem_wdata = last_val;
    if (accept && (count < kthsel_pkg::cnt_t'(kthsel_pkg::MAX_RANK))) begin
      mem_we    = 1'b1;
      mem_waddr = count[kthsel_pkg::IDX_W-1:0];
      mem_wdata = in_ch.value;
    end else if (state == S_ACT) begin
      case (op)
        kthsel_pkg::OP_REPLACE: begin
          mem_we    = (in_val > min_val);
          mem_wdata = in_val;
        end
        kthsel_pkg::OP_DROP: begin
          mem_we    = 1'b1;
          mem_wdata = last_val;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_idx[kthsel_pkg::IDX_W-1:0]];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= kthsel_pkg::OP_RESULT;
      rank_k    <= kthsel_pkg::rank_t'(1);
      count     <= '0;
      rd_idx    <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        rank_k <= cfg_wdata;
      end
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      rd_valid <= issue;
      if (issue) begin
        rd_idx <= rd_idx + kthsel_pkg::cnt_t'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (count < kthsel_pkg::cnt_t'(kthsel_pkg::MAX_RANK)) begin
              count <= count + kthsel_pkg::cnt_t'(1);
              state <= S_CHECK;
            end else begin
              op       <= kthsel_pkg::OP_REPLACE;
              rd_idx   <= '0;
              rd_valid <= 1'b0;
              state    <= S_SCAN;
            end
          end
        end
        S_CHECK: begin
          rd_idx   <= '0;
          rd_valid <= 1'b0;
          if (count > k_eff) begin
            op    <= kthsel_pkg::OP_DROP;
            state <= S_SCAN;
          end else if (in_last) begin
            op    <= kthsel_pkg::OP_RESULT;
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          case (op)
            kthsel_pkg::OP_REPLACE: begin
              state <= S_CHECK;
            end
            kthsel_pkg::OP_DROP: begin
              count <= count - kthsel_pkg::cnt_t'(1);
              state <= S_CHECK;
            end
            default: begin
              if (emit) begin
                out_valid <= 1'b1;
                count     <= '0;
                state     <= S_IDLE;
              end
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_val  <= in_ch.value;
      in_last <= in_ch.last_of_set;
    end
    if (rd_valid) begin
      // running minimum, first strictly smaller entry wins
      if ((rd_tag == '0) || (rdata < min_val)) begin
        min_val <= rdata;
        min_idx <= rd_tag;
      end
      if (tag_is_last) begin
        last_val <= rdata;
      end
    end
    rd_tag <= rd_idx[kthsel_pkg::IDX_W-1:0];
    if (emit) begin
      kth_value    <= min_val;
      fewer_than_k <= (count < k_eff);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= kthsel_pkg::cnt_t'(kthsel_pkg::MAX_RANK))
    else $error("kept count above store size");

  a_scan_reads_kept: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ({1'b0, rd_tag} < count))
    else $error("scan read an entry beyond the kept count");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> (count == '0) && out_valid && (state == S_IDLE))
    else $error("result not followed by an empty store");

endmodule

`default_nettype wire

FILE: tb/kth_largest_topk_select_top_test.sv
// kth_largest_topk_select_top_test: self-checking bench for the k-th largest selector,
// streams signed sets under several rank settings and checks each result against a
// min-store predictor; depends on kthsel_pkg, kthsel_if and kth_largest_topk_select_top

module kth_largest_topk_select_top_test;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int OPEN_SETTLE  = 6000;   // drop scans after a rank cut can run long
  localparam int HOLD_CYCLES  = 500;
  localparam kthsel_pkg::data_t DATA_MAX = kthsel_pkg::data_t'(32'h7fff_ffff);
  localparam kthsel_pkg::data_t DATA_MIN = kthsel_pkg::data_t'(32'h8000_0000);

  typedef struct {
    kthsel_pkg::data_t value;
    logic              last_of_set;
  } set_elem_t;

  typedef struct {
    kthsel_pkg::data_t kth_value;
    logic              fewer_than_k;
  } kth_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  kthsel_pkg::rank_t cfg_wdata;

  kthsel_in_if  in_bus();
  kthsel_out_if out_bus();

  kth_largest_topk_select_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  // predictor state
  kthsel_pkg::data_t kept_vals [kthsel_pkg::MAX_RANK];
  int                kept_cnt    = 0;
  kthsel_pkg::rank_t rank_shadow = kthsel_pkg::rank_t'(1);
  kth_result_t       kth_expected[$];

  set_elem_t   value_queue[$];
  int          items_queued    = 0;
  int          items_accepted  = 0;
  int          sets_closed     = 0;
  int          results_checked = 0;
  int          short_results   = 0;
  int          ranks_written   = 0;
  int          mid_set_changes = 0;
  int          store_full_sets = 0;
  int          fail_count      = 0;
  int          cycle_count     = 0;
  int          burst_left      = 0;
  int          gap_left        = 0;
  int          rx_cycle        = 0;
  int          rx_mode         = 0;
  int          hold_left       = 0;
  int          hold_requests   = 0;
  int          holds_served    = 0;
  logic        set_open        = 1'b0;

  function automatic int rank_in_force(input kthsel_pkg::rank_t k);
    if (k == 0) return 1;
    if (int'(k) > kthsel_pkg::MAX_RANK) return kthsel_pkg::MAX_RANK;
    return int'(k);
  endfunction

  function automatic int smallest_slot();
    int best;
    best = 0;
    for (int i = 1; i < kept_cnt; i++) begin
      if (kept_vals[i] < kept_vals[best]) best = i;
    end
    return best;
  endfunction

  // fold one transferred value into the kept multiset
  task automatic absorb_value(input kthsel_pkg::data_t v, input logic last);
    int          lim;
    int          m;
    kth_result_t r;
    lim = rank_in_force(rank_shadow);
    if (kept_cnt < kthsel_pkg::MAX_RANK) begin
      kept_vals[kept_cnt] = v;
      kept_cnt++;
    end else begin
      m = smallest_slot();
      if (v > kept_vals[m]) kept_vals[m] = v;
    end
    while (kept_cnt > lim) begin
      m = smallest_slot();
      kept_vals[m] = kept_vals[kept_cnt-1];
      kept_cnt--;
    end
    if (last) begin
      m = smallest_slot();
      r.kth_value    = kept_vals[m];
      r.fewer_than_k = (kept_cnt < lim);
      kth_expected.push_back(r);
      kept_cnt = 0;
    end
  endtask

  function automatic int draw_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5, 6, 7: return $urandom_range(1, 4);
      default:    return $urandom_range(5, 80);
    endcase
  endfunction

  function automatic kthsel_pkg::data_t draw_value(input int style);
    case (style)
      0: return kthsel_pkg::data_t'($urandom);
      1: return kthsel_pkg::data_t'(int'($urandom_range(0, 6)) - 3);
      2: begin
        case ($urandom_range(0, 4))
          0: return DATA_MAX;
          1: return DATA_MIN;
          2: return kthsel_pkg::data_t'(0);
          3: return kthsel_pkg::data_t'(-1);
          default: return kthsel_pkg::data_t'($urandom);
        endcase
      end
      default: return kthsel_pkg::data_t'(int'($urandom_range(0, 1000)) - 500);
    endcase
  endfunction

  task automatic push_value(input kthsel_pkg::data_t v, input logic last);
    set_elem_t e;
    e.value       = v;
    e.last_of_set = last;
    value_queue.push_back(e);
    items_queued++;
    if (last) sets_closed++;
    set_open = !last;
  endtask

  task automatic push_set(input int n, input logic close);
    int style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      push_value(draw_value(style), close && (i == n - 1));
    end
  endtask

  // wait until every value is transferred and every result is back
  task automatic drain();
    do @(negedge clk);
    while (value_queue.size() != 0 || in_bus.valid || kth_expected.size() != 0);
    if (kept_cnt != 0) repeat (OPEN_SETTLE) @(negedge clk);
    else repeat (8) @(negedge clk);
  endtask

  task automatic write_rank(input kthsel_pkg::rank_t k);
    drain();
    if (kept_cnt != 0) mid_set_changes++;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rank_shadow = k;
    ranks_written++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // value sender: bursts of random length separated by random gaps
  always @(posedge clk) begin : value_sender
    set_elem_t nxt;
    if (rst) begin
      in_bus.valid       <= 1'b0;
      in_bus.value       <= '0;
      in_bus.last_of_set <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        absorb_value(in_bus.value, in_bus.last_of_set);
        items_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (value_queue.size() != 0) begin
          nxt = value_queue.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.value       <= nxt.value;
          in_bus.last_of_set <= nxt.last_of_set;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = draw_gap();
          end else begin
            burst_left--;
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stall patterns, long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= (rx_cycle % 4 != 3);
          2:       out_bus.ready <= ($urandom_range(0, 1) == 1);
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    kth_result_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (kth_expected.size() == 0) begin
        $error("result with nothing pending: kth_value=%0d fewer_than_k=%0b",
               out_bus.kth_value, out_bus.fewer_than_k);
        fail_count++;
      end else begin
        want = kth_expected.pop_front();
        if (out_bus.kth_value !== want.kth_value) begin
          $error("kth_value: expected %0d, got %0d", want.kth_value, out_bus.kth_value);
          fail_count++;
        end
        if (out_bus.fewer_than_k !== want.fewer_than_k) begin
          $error("fewer_than_k: expected %0b, got %0b",
                 want.fewer_than_k, out_bus.fewer_than_k);
          fail_count++;
        end
        results_checked++;
        if (want.fewer_than_k) short_results++;
      end
    end
  end

  initial begin : stimulus
    kthsel_pkg::rank_t k;
    int    e;
    int    n;
    int    nsets;
    int    target;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // rank 1 out of reset: the largest of the extremes wins
    push_value(DATA_MIN, 1'b0);
    push_value(DATA_MAX, 1'b0);
    push_value(kthsel_pkg::data_t'(0), 1'b0);
    push_value(kthsel_pkg::data_t'(-1), 1'b1);
    // zero rank acts as one
    write_rank(kthsel_pkg::rank_t'(0));
    push_value(kthsel_pkg::data_t'(5), 1'b0);
    push_value(kthsel_pkg::data_t'(-7), 1'b1);
    // short sets and tied values
    write_rank(kthsel_pkg::rank_t'(3));
    push_value(kthsel_pkg::data_t'(42), 1'b1);
    push_value(kthsel_pkg::data_t'(1), 1'b0);
    push_value(kthsel_pkg::data_t'(1), 1'b0);
    push_value(kthsel_pkg::data_t'(1), 1'b0);
    push_value(kthsel_pkg::data_t'(-3), 1'b1);
    push_value(DATA_MIN, 1'b0);
    push_value(DATA_MIN, 1'b1);
    // rank cut while a set is open: surplus dropped on the next value
    push_value(kthsel_pkg::data_t'(10), 1'b0);
    push_value(kthsel_pkg::data_t'(20), 1'b0);
    push_value(kthsel_pkg::data_t'(30), 1'b0);
    write_rank(kthsel_pkg::rank_t'(1));
    push_value(kthsel_pkg::data_t'(5), 1'b1);
    // ranks above the store size clamp to it
    write_rank(kthsel_pkg::rank_t'(127));
    push_value(kthsel_pkg::data_t'(-1), 1'b0);
    push_value(DATA_MAX, 1'b0);
    push_value(kthsel_pkg::data_t'(0), 1'b1);
    write_rank(kthsel_pkg::rank_t'(65));
    push_value(kthsel_pkg::data_t'(7), 1'b0);
    push_value(kthsel_pkg::data_t'(-9), 1'b1);

    target = items_queued + RANDOM_ITEMS;
    while (items_queued < target) begin
      case ($urandom_range(0, 9))
        0:          k = kthsel_pkg::rank_t'(0);
        1:          k = kthsel_pkg::rank_t'(1);
        2:          k = kthsel_pkg::rank_t'(kthsel_pkg::MAX_RANK);
        3:          k = kthsel_pkg::rank_t'($urandom_range(65, 127));
        4:          k = kthsel_pkg::rank_t'($urandom_range(0, 127));
        5, 6, 7:    k = kthsel_pkg::rank_t'($urandom_range(2, 8));
        default:    k = kthsel_pkg::rank_t'($urandom_range(9, 63));
      endcase
      write_rank(k);
      e = rank_in_force(k);
      nsets = $urandom_range(4, 14);
      for (int s = 0; s < nsets; s++) begin
        if (e <= 16) begin
          case ($urandom_range(0, 9))
            0, 1:    n = (e > 1) ? $urandom_range(1, e - 1) : 1;
            2:       n = $urandom_range(e + 9, e + 40);
            default: n = $urandom_range(e, e + 8);
          endcase
        end else begin
          case ($urandom_range(0, 7))
            0: begin
              n = $urandom_range(e, e + 6);
              if (e == kthsel_pkg::MAX_RANK && n > kthsel_pkg::MAX_RANK) store_full_sets++;
            end
            default: n = $urandom_range(1, 12);
          endcase
        end
        push_set(n, 1'b1);
      end
      // leave a set open now and then so the next rank lands mid-set
      if ($urandom_range(0, 3) == 0 && items_queued < target) push_set($urandom_range(1, 5), 1'b0);
      // first block always gets a long receiver hold while its values stream in
      if (hold_requests == 0 || $urandom_range(0, 3) == 0) hold_requests++;
    end
    if (set_open) push_value(draw_value(0), 1'b1);

    drain();
    repeat (100) @(negedge clk);
    $display("covered %0d values in %0d sets, %0d results checked (%0d short sets)",
             items_accepted, sets_closed, results_checked, short_results);
    $display("%0d rank writes, %0d rank changes inside a set, %0d sets overflowing a full store",
             ranks_written, mid_set_changes, store_full_sets);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
